>>> src/srg_pkg.sv
// ----------------------------------------------------------------------------
// Subtractive generator package
// Shared widths, constants, types and the modular subtract helper.
// ----------------------------------------------------------------------------
package srg_pkg;

	localparam int WORD_W    = 30;
	localparam int SEED_W    = 32;
	localparam int RANGE_W   = 21;
	localparam int QUO_W     = 21;
	localparam int PROD_W    = WORD_W + RANGE_W;
	localparam int TABLE_LEN = 55;
	localparam int IDX_W     = 6;
	localparam int TRAIL_OFF = 31;
	localparam int FILL_STEP = 21;
	localparam int MIX_STEPS = 4 * TABLE_LEN;
	localparam int CNT_W     = 8;

	localparam logic [WORD_W-1:0]  MOD_BIG   = 30'd1000000000;
	localparam logic [SEED_W-1:0]  SEED_BASE = 32'd161803398;
	localparam logic [RANGE_W-1:0] RANGE_RST = 21'd1;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Difference of two residues, modulo 10^9.
	function automatic word_t sub_mod(input word_t a, input word_t b);
		word_t r;
		r = a - b;
		if (a < b) begin
			r = r + MOD_BIG;
		end
		return r;
	endfunction

endpackage

>>> src/srg_cell.sv
// ----------------------------------------------------------------------------
// Table cell
// One word of the lag table; shifts from its neighbor or loads a fill value.
// ----------------------------------------------------------------------------
module srg_cell import srg_pkg::*; (
	input  logic  clk,
	input  logic  shift_en,
	input  word_t shift_d,
	input  logic  load_en,
	input  word_t load_d,
	output word_t word
);

	word_t word_q;

	always_ff @(posedge clk) begin
		if (load_en) begin
			word_q <= load_d;
		end else if (shift_en) begin
			word_q <= shift_d;
		end
	end

	assign word = word_q;

endmodule

>>> src/srg_div.sv
// ----------------------------------------------------------------------------
// Scaling divider
// Divides the scaled product by 10^9 with a reciprocal multiply and one
// correction step; the product, the multiply, the estimate and the quotient are registered in turn.
// ----------------------------------------------------------------------------
module srg_div import srg_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [PROD_W-1:0]   dividend,
	output div_stat_t           stat,
	output logic [QUO_W-1:0]    quotient
);

	localparam int                HEAD_W = 32;
	localparam int                DROP_W = PROD_W - HEAD_W;
	localparam int                MUL_W  = 2 * HEAD_W;
	localparam int                SHIFT  = 42;
	localparam logic [HEAD_W-1:0] RECIP  = 32'd2305843009;

	logic              valid_s1;
	logic              valid_s2;
	logic              valid_s3;
	logic              done_q;
	logic [PROD_W-1:0] prod_s1;
	logic [MUL_W-1:0]  mul_s2;
	logic [QUO_W-1:0]  est_s3;
	logic [PROD_W-1:0] back_s3;
	logic [QUO_W-1:0]  quo_q;
	logic [QUO_W-1:0]  est;
	logic [PROD_W-1:0] rem;

	// The estimate is never above the true quotient and at most one below it.
	assign est = mul_s2[SHIFT+QUO_W-1:SHIFT];
	assign rem = prod_s1 - back_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			if (start) begin
				done_q <= 1'b0;
			end else if (valid_s3) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= dividend;
		end
		if (valid_s1) begin
			mul_s2 <= MUL_W'(prod_s1[PROD_W-1:DROP_W]) * MUL_W'(RECIP);
		end
		if (valid_s2) begin
			est_s3  <= est;
			back_s3 <= PROD_W'(est) * PROD_W'(MOD_BIG);
		end
		if (valid_s3) begin
			quo_q <= (rem >= PROD_W'(MOD_BIG)) ? (est_s3 + 1'b1) : est_s3;
		end
	end

	assign stat.busy = valid_s1 || valid_s2 || valid_s3;
	assign stat.done = done_q;
	assign quotient  = quo_q;

	a_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !(valid_s1 || valid_s2 || valid_s3))
		else $error("Divider started while busy.");

	a_estimate_fits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> mul_s2[MUL_W-1:SHIFT+QUO_W] == '0)
		else $error("Quotient estimate overflowed.");

	a_estimate_close: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> rem < {MOD_BIG, 1'b0})
		else $error("Quotient estimate off by more than one.");

endmodule

>>> src/subtractive_random_generator_top.sv
// ----------------------------------------------------------------------------
// Subtractive random generator
// Lagged subtractive generator modulo 10^9 with a scaled draw output.
// ----------------------------------------------------------------------------
// Each request yields one result. A plain draw steps the table, forms the
// scaling product, divides it by 10^9 in the reciprocal divider and loads the
// output register; a new request is accepted only after that result has been
// loaded. A request with a negative seed, and the first request after reset,
// first rebuilds the table: setup of the seed distance and first word, a fill
// of all 55 cells and 220 mixing steps through the ring of table cells. A new
// request is taken while the previous result still waits at the output; a
// finished result waits until the output is free.
module subtractive_random_generator_top import srg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [31:0]        s_axis_tdata,   // [31:0] seed
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [55:0]        m_axis_tdata,   // [29:0] raw_value, [50:30] scaled_draw
	input  logic               cfg_wr_en,
	input  logic [RANGE_W-1:0] cfg_wr_data
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DIST   = 3'd1;
	localparam logic [2:0] ST_SEED   = 3'd2;
	localparam logic [2:0] ST_FILL   = 3'd3;
	localparam logic [2:0] ST_MIX    = 3'd4;
	localparam logic [2:0] ST_STEP   = 3'd5;
	localparam logic [2:0] ST_MUL    = 3'd6;
	localparam logic [2:0] ST_RESULT = 3'd7;

	logic [2:0]         state_q;
	logic               seeded_q;
	logic [RANGE_W-1:0] range_top_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   pos_q;
	logic [SEED_W-1:0]  mag_q;
	logic [SEED_W-1:0]  dist_q;
	word_t              cur_q;
	word_t              prv_q;
	word_t              raw_q;
	logic               out_valid_q;
	word_t              out_raw_q;
	logic [QUO_W-1:0]   out_scaled_q;

	word_t              words [TABLE_LEN];
	word_t              new_word;
	logic               ring_shift;
	logic               fill_en;
	logic [IDX_W-1:0]   fill_cell;
	logic [SEED_W-1:0]  seed_mag;
	logic [SEED_W-1:0]  seed_dist;
	logic [SEED_W-1:0]  dist_red;
	logic [IDX_W:0]     pos_sum;
	logic               in_req;
	logic               out_free;
	logic               result_load;
	logic               div_start;
	logic [PROD_W-1:0]  product;
	div_stat_t          div_stat;
	logic [QUO_W-1:0]   quotient;

	assign in_req      = s_axis_tvalid && s_axis_tready;
	assign out_free    = !out_valid_q || m_axis_tready;
	assign result_load = (state_q == ST_RESULT) && div_stat.done && out_free;

	assign seed_mag  = s_axis_tdata[SEED_W-1] ? (~s_axis_tdata + 1'b1) : s_axis_tdata;
	assign seed_dist = (mag_q >= SEED_BASE) ? (mag_q - SEED_BASE) : (SEED_BASE - mag_q);
	assign dist_red  = (dist_q >= SEED_W'(MOD_BIG)) ? (dist_q - SEED_W'(MOD_BIG)) : dist_q;
	assign pos_sum   = {1'b0, pos_q} + (IDX_W + 1)'(FILL_STEP);

	assign ring_shift = (state_q == ST_MIX) || (state_q == ST_STEP);
	assign fill_en    = (state_q == ST_FILL);
	assign fill_cell  = (pos_q == '0) ? IDX_W'(TABLE_LEN - 1) : (pos_q - 1'b1);
	assign new_word   = sub_mod(words[0], words[TRAIL_OFF]);

	genvar k;
	generate
		for (k = 0; k < TABLE_LEN; k++) begin : g_cell
			word_t shift_d;
			if (k == TABLE_LEN - 1) begin : g_tail
				assign shift_d = new_word;
			end else begin : g_body
				assign shift_d = words[k + 1];
			end
			srg_cell u_cell (
				.clk      (clk),
				.shift_en (ring_shift),
				.shift_d  (shift_d),
				.load_en  (fill_en && (fill_cell == IDX_W'(k))),
				.load_d   (cur_q),
				.word     (words[k])
			);
		end
	endgenerate

	assign div_start = (state_q == ST_MUL);
	assign product   = PROD_W'(range_top_q) * PROD_W'(raw_q);

	srg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (product),
		.stat     (div_stat),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_top_q <= RANGE_RST;
		end else if (cfg_wr_en) begin
			range_top_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seeded_q    <= 1'b0;
			cnt_q       <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (result_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_req) begin
						if (s_axis_tdata[SEED_W-1] || !seeded_q) begin
							state_q <= ST_DIST;
						end else begin
							state_q <= ST_STEP;
						end
					end
				end
				ST_DIST: begin
					state_q <= ST_SEED;
				end
				ST_SEED: begin
					cnt_q   <= '0;
					pos_q   <= '0;
					state_q <= ST_FILL;
				end
				ST_FILL: begin
					pos_q <= (pos_sum >= (IDX_W + 1)'(TABLE_LEN)) ?
						IDX_W'(pos_sum - (IDX_W + 1)'(TABLE_LEN)) : IDX_W'(pos_sum);
					if (cnt_q == CNT_W'(TABLE_LEN - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_MIX;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_MIX: begin
					if (cnt_q == CNT_W'(MIX_STEPS - 1)) begin
						seeded_q <= 1'b1;
						state_q  <= ST_STEP;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_STEP: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (result_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_req) begin
			mag_q <= seed_mag;
		end
		if (state_q == ST_DIST) begin
			dist_q <= seed_dist;
		end
		if (state_q == ST_SEED) begin
			cur_q <= dist_red[WORD_W-1:0];
		end else if (fill_en) begin
			cur_q <= (cnt_q == '0) ? word_t'(1) : sub_mod(prv_q, cur_q);
			prv_q <= cur_q;
		end
		if (state_q == ST_STEP) begin
			raw_q <= new_word;
		end
		if (result_load) begin
			out_raw_q    <= raw_q;
			out_scaled_q <= quotient + 1'b1;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_scaled_q, out_raw_q};

	a_step_needs_seed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) |-> seeded_q)
		else $error("Draw taken from an unseeded table.");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_RESULT) && (state_q == ST_IDLE))
		else $error("Result raised outside the result state.");

	a_raw_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> raw_q < MOD_BIG)
		else $error("Table word out of range.");

	a_div_settled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESULT) && div_stat.done |-> !div_stat.busy)
		else $error("Divider reported a result while still running.");

endmodule

>>> tb/srg_draw_checker.sv
// ----------------------------------------------------------------------------
// Subtractive generator draw checker
// Watches the request, result and register channels of the generator. It keeps
// its own lagged table, pointers and range, and works out each draw when its
// request is accepted. Each result is compared, field by field, with the
// oldest draw still due. It reports mismatches and hands back the count of
// failures and of draws still outstanding.
// ----------------------------------------------------------------------------
module srg_draw_checker import srg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	input  logic               s_axis_tready,
	input  logic [31:0]        s_axis_tdata,   // [31:0] seed
	input  logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	input  logic [55:0]        m_axis_tdata,   // [29:0] raw_value, [50:30] scaled_draw
	input  logic               cfg_wr_en,
	input  logic [RANGE_W-1:0] cfg_wr_data,
	output int                 mismatch_count,
	output int                 draws_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint MODULUS     = 1000000000;
	localparam longint SEED_OFFSET = 161803398;
	localparam int     PRINT_LIMIT = 50;

	typedef struct packed {
		logic [RANGE_W-1:0] scaled_draw;
		word_t              raw_value;
	} draw_t;

	word_t              lag_words [1:TABLE_LEN];
	int                 lead_idx;
	int                 trail_idx;
	bit                 table_ready;
	logic [RANGE_W-1:0] range_top;
	draw_t              draws_due [$];

	initial begin
		mismatch_count = 0;
		draws_pending = 0;
	end

	task automatic report_mismatch(input string what, input longint want, input longint got);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT) begin
			$display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	function automatic void rebuild_table(input logic [31:0] seed_bits);
		longint mag;
		longint m;
		longint k;
		longint diff;
		int     slot;
		mag = longint'($signed(seed_bits));
		if (mag < 0) begin
			mag = -mag;
		end
		m = SEED_OFFSET - mag;
		if (m < 0) begin
			m = -m;
		end
		m = m % MODULUS;
		lag_words[TABLE_LEN] = word_t'(m);
		k = 1;
		for (int i = 1; i < TABLE_LEN; i++) begin
			slot = (FILL_STEP * i) % TABLE_LEN;
			lag_words[slot] = word_t'(k);
			k = m - k;
			if (k < 0) begin
				k += MODULUS;
			end
			m = longint'(lag_words[slot]);
		end
		for (int pass = 0; pass < 4; pass++) begin
			for (int i = 1; i <= TABLE_LEN; i++) begin
				diff = longint'(lag_words[i]) - longint'(lag_words[1 + (i + 30) % TABLE_LEN]);
				if (diff < 0) begin
					diff += MODULUS;
				end
				lag_words[i] = word_t'(diff);
			end
		end
		lead_idx = 0;
		trail_idx = TRAIL_OFF;
		table_ready = 1'b1;
	endfunction

	function automatic draw_t next_draw(input logic [31:0] seed_bits);
		draw_t  d;
		longint diff;
		if (seed_bits[31] || !table_ready) begin
			rebuild_table(seed_bits);
		end
		lead_idx = (lead_idx >= TABLE_LEN) ? 1 : lead_idx + 1;
		trail_idx = (trail_idx >= TABLE_LEN) ? 1 : trail_idx + 1;
		diff = longint'(lag_words[lead_idx]) - longint'(lag_words[trail_idx]);
		if (diff < 0) begin
			diff += MODULUS;
		end
		lag_words[lead_idx] = word_t'(diff);
		d.raw_value = word_t'(diff);
		d.scaled_draw = RANGE_W'(longint'(range_top) * diff / MODULUS + 1);
		return d;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		draw_t got;
		draw_t want;
		if (!arst_n) begin
			lead_idx = 0;
			trail_idx = TRAIL_OFF;
			table_ready = 1'b0;
			range_top = RANGE_RST;
			draws_due.delete();
			draws_pending <= 0;
		end else begin
			if (cfg_wr_en) begin
				range_top = cfg_wr_data;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[WORD_W+RANGE_W-1:0];
				if (draws_due.size() == 0) begin
					report_mismatch("result with no request waiting", -1,
						longint'(got.raw_value));
				end else begin
					want = draws_due.pop_front();
					if (got.raw_value !== want.raw_value) begin
						report_mismatch("raw_value", longint'(want.raw_value),
							longint'(got.raw_value));
					end
					if (got.scaled_draw !== want.scaled_draw) begin
						report_mismatch("scaled_draw", longint'(want.scaled_draw),
							longint'(got.scaled_draw));
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				draws_due = {draws_due, next_draw(s_axis_tdata)};
			end
			draws_pending <= draws_due.size();
		end
	end

endmodule

>>> tb/subtractive_random_generator_top_test.sv
// ----------------------------------------------------------------------------
// Subtractive random generator testbench
// Drives draw requests with directed and random seeds through several range
// settings and idle patterns, including a long result hold-off that backs up
// the request side. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module subtractive_random_generator_top_test import srg_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 320;
	localparam int HOLD_CYCLES   = 600;
	localparam int PHASE_ITEMS   = 200;
	localparam int PHASES        = 8;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [31:0]        s_axis_tdata = '0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [55:0]        m_axis_tdata;
	logic               cfg_wr_en = 1'b0;
	logic [RANGE_W-1:0] cfg_wr_data = '0;

	int                 mismatch_count;
	int                 draws_pending;
	int                 cycle_count = 0;
	int unsigned        send_idle_pct = 0;
	int unsigned        recv_stall_pct = 0;
	bit                 hold_request = 1'b0;
	bit                 hold_active = 1'b0;

	int unsigned        send_plan [4] = '{0, 87, 0, 31};
	int unsigned        recv_plan [4] = '{0, 0, 87, 31};
	logic [31:0]        directed_seeds [20] = '{
		32'd1, 32'd0, 32'd12345, 32'h7FFFFFFF, 32'h80000000,
		32'd0, 32'hFFFFFFFF, -32'sd161803398, 32'd161803398, -32'sd1161803398,
		32'h55555555, 32'hAAAAAAAA, 32'h80000001, 32'd1, 32'hFFFFFFFF,
		32'h7FFFFFFF, 32'hDEADBEEF, 32'd2, 32'd3, 32'hFFFFFFFE
	};
	logic [RANGE_W-1:0] range_plan [PHASES];

	subtractive_random_generator_top uut (.*);

	srg_draw_checker draw_checker (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

	always @(posedge clk) begin
		if (hold_active) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		wait (hold_request);
		hold_active <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_active <= 1'b0;
	end

	function automatic logic [31:0] random_seed();
		if ($urandom_range(39) == 0) begin
			return {1'b1, 31'($urandom)};
		end
		return {1'b0, 31'($urandom)};
	endfunction

	task automatic send_seed(input logic [31:0] seed);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= seed;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain_results(input int settle);
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (draws_pending != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_range(input logic [RANGE_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		range_plan = '{21'd0, 21'h1FFFFF, 21'd1, 21'($urandom), 21'd1048576,
			21'($urandom_range(1, 1048576)), 21'd7, 21'($urandom)};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_range(21'd1048576);
		foreach (directed_seeds[i]) begin
			send_seed(directed_seeds[i]);
		end
		drain_results(2);

		hold_request <= 1'b1;
		repeat (40) send_seed(random_seed());
		drain_results(2);

		for (int phase = 0; phase < PHASES; phase++) begin
			send_idle_pct <= send_plan[phase % 4];
			recv_stall_pct <= recv_plan[phase % 4];
			write_range(range_plan[phase]);
			repeat (PHASE_ITEMS) send_seed(random_seed());
			drain_results(2);
		end

		drain_results(SETTLE_CYCLES);
		if (mismatch_count == 0 && draws_pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
